// ----- rtl/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the relation property checker
// Holds the matrix geometry, the opcodes and the broadcast control struct.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int NUM_ROWS = 16;
    localparam int ROW_W    = 4;
    localparam int CNT_W    = 9;
    localparam int DOMAIN_SIZE_DEF = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    // The spare opcode behaves as a query.
    localparam logic [1:0] OP_SPARE  = 2'd3;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                bcast_en;   // compare the cells against the row of bcast_idx on the bus
        logic [ROW_W-1:0]    bcast_idx;  // row being compared this cycle
        logic                wr_en;      // update row first_elem
        logic [ROW_W-1:0]    wr_row;
        logic [NUM_ROWS-1:0] wr_data;
    } rpc_ctrl_t;

endpackage

// ----- rtl/rpc_cell.sv -----
// ----------------------------------------------------------------------------
// rpc_cell: one matrix row
// Stores one row, compares it against the broadcast row and passes the
// running flags on to the next cell of the chain.
// ----------------------------------------------------------------------------
module rpc_cell
    import rpc_pkg::*;
#(
    parameter logic [ROW_W-1:0] ROW_ID = '0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rpc_ctrl_t           ctrl,
    input  logic [NUM_ROWS-1:0] bus_in,    // broadcast row from the bus
    output logic [NUM_ROWS-1:0] row_out,
    input  logic [2:0]          flags_in,  // sym, anti, trans from upstream
    output logic [2:0]          flags_out
);

    logic [NUM_ROWS-1:0] row_reg;
    logic [NUM_ROWS-1:0] row_next;
    logic                hit;
    logic                sym_ok;
    logic                anti_ok;
    logic                trans_ok;

    always_comb begin
        row_next = row_reg;
        if (ctrl.wr_en && ctrl.wr_row == ROW_ID) begin
            row_next = ctrl.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    assign row_out = row_reg;

    // The broadcast row c is checked against this row r:
    // (r,c) off-diagonal needs (c,r) for symmetry and forbids it for antisymmetry;
    // (r,c) stored needs row c to be a subset of row r for transitivity.
    assign hit      = ctrl.bcast_en && row_reg[ctrl.bcast_idx];
    assign sym_ok   = !(hit && ctrl.bcast_idx != ROW_ID && !bus_in[ROW_ID]);
    assign anti_ok  = !(hit && ctrl.bcast_idx != ROW_ID && bus_in[ROW_ID]);
    assign trans_ok = !(hit && (bus_in & ~row_reg) != '0);

    assign flags_out = flags_in & {sym_ok, anti_ok, trans_ok};

endmodule

// ----- rtl/relation_property_checker_unit.sv -----
// ----------------------------------------------------------------------------
// relation_property_checker_unit: binary relation matrix with property flags
// Sixteen row cells hold the relation; a sequencer updates one row and then
// broadcasts every row in turn to gather symmetry, antisymmetry and
// transitivity, while diagonal and mapping come from the rows at once and the count from a counter.
// ----------------------------------------------------------------------------
//  channel  | ports            | direction | role
//  s_       | valid/ready      | in        | opcode and pair transaction
//  m_       | valid/ready      | out       | result transaction with flags
//  cfg      | cfg_wr_en/data   | in        | domain mask write
//
// After a transaction is accepted, the sequencer updates the row, broadcasts
// every row in turn on the shared bus and then latches the result. Reset
// clears all rows, the count and the mask. A stalled result holds the block;
// the next transaction can be accepted in the cycle after the result is
// taken.
module relation_property_checker_unit
    import rpc_pkg::*;
#(
    parameter int DOMAIN_SIZE = DOMAIN_SIZE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [3:0]          s_first_elem,
    input  logic [3:0]          s_second_elem,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_accepted,
    output logic                m_pair_present,
    output logic [15:0]         m_image_row,
    output logic [8:0]          m_pair_count,
    output logic                m_is_reflexive,
    output logic                m_is_irreflexive,
    output logic                m_is_symmetric,
    output logic                m_is_antisymmetric,
    output logic                m_is_transitive,
    output logic                m_is_mapping
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_UPD   = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // Domain limit: elements at or above DOMAIN_SIZE never belong.
    function automatic logic [NUM_ROWS-1:0] size_mask();
        logic [NUM_ROWS-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (i < DOMAIN_SIZE) m[i] = 1'b1;
        end
        return m;
    endfunction

    localparam logic [NUM_ROWS-1:0] SIZE_MASK = size_mask();

    logic [1:0]          state_reg, state_next;
    logic [15:0]         dom_reg;
    logic [1:0]          op_reg;
    logic [ROW_W-1:0]    a_reg, b_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                acc_reg, acc_next;
    logic [ROW_W-1:0]    idx_reg;
    logic [2:0]          fl_reg, fl_next;
    logic                mv_reg;

    rpc_ctrl_t           ctrl;
    logic [NUM_ROWS-1:0] rows [NUM_ROWS];
    logic [2:0]          chain [NUM_ROWS+1];
    logic [NUM_ROWS-1:0] bus;
    logic [NUM_ROWS-1:0] dom;
    logic [NUM_ROWS-1:0] row_a;
    logic [NUM_ROWS-1:0] diag;
    logic                map_ok;

    assign dom   = dom_reg & SIZE_MASK;
    assign row_a = rows[a_reg];
    assign bus   = rows[idx_reg];

    // Row cells in a chain; each ANDs its verdict into the running flags.
    assign chain[0] = 3'b111;
    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_cell
        rpc_cell #(.ROW_ID(ROW_W'(g))) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .bus_in    (bus),
            .row_out   (rows[g]),
            .flags_in  (chain[g]),
            .flags_out (chain[g+1])
        );
    end

    always_comb begin
        map_ok = 1'b1;
        for (int i = 0; i < NUM_ROWS; i++) begin
            diag[i] = rows[i][i];
            if ((rows[i] & (rows[i] - 1'b1)) != '0) map_ok = 1'b0;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        fl_next      = fl_reg;
        ctrl         = '0;
        ctrl.bcast_idx = idx_reg;
        ctrl.wr_row  = a_reg;
        ctrl.wr_data = row_a;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_UPD;
            end
            ST_UPD: begin
                acc_next = 1'b1;
                fl_next  = 3'b111;
                state_next = ST_SCAN;
                if (op_reg == OP_ADD) begin
                    if (!dom[a_reg] || !dom[b_reg] || row_a[b_reg]) begin
                        acc_next = 1'b0;
                    end else begin
                        ctrl.wr_en = 1'b1;
                        ctrl.wr_data[b_reg] = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else if (op_reg == OP_REMOVE && row_a[b_reg]) begin
                    ctrl.wr_en = 1'b1;
                    ctrl.wr_data[b_reg] = 1'b0;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SCAN: begin
                ctrl.bcast_en = 1'b1;
                fl_next = fl_reg & chain[NUM_ROWS];
                if (idx_reg == ROW_W'(NUM_ROWS - 1)) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready || !mv_reg) state_next = mv_reg ? ST_IDLE : ST_OUT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dom_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) dom_reg <= cfg_wr_data;
            if (state_reg == ST_SCAN) idx_reg <= idx_reg + 1'b1;
            else                      idx_reg <= '0;
            if (state_reg == ST_OUT && !mv_reg) mv_reg <= 1'b1;
            else if (mv_reg && m_ready)         mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        fl_reg  <= fl_next;
        if (s_valid && s_ready) begin
            op_reg <= s_opcode;
            a_reg  <= s_first_elem;
            b_reg  <= s_second_elem;
        end
        if (state_reg == ST_OUT && !mv_reg) begin
            m_accepted         <= acc_reg;
            m_pair_present     <= row_a[b_reg];
            m_image_row        <= row_a;
            m_pair_count       <= cnt_reg;
            m_is_reflexive     <= (dom & ~diag) == '0;
            m_is_irreflexive   <= (dom & diag) == '0;
            m_is_symmetric     <= fl_reg[2];
            m_is_antisymmetric <= fl_reg[1];
            m_is_transitive    <= fl_reg[0];
            m_is_mapping       <= map_ok;
        end
    end

    assign m_valid = mv_reg;

endmodule

// ----- rtl/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_checker: port-level checks for the relation property checker
// Watches handshakes and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
module rpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_pair_present,
    input logic [15:0] m_image_row,
    input logic [8:0]  m_pair_count,
    input logic        m_is_reflexive,
    input logic        m_is_irreflexive
);

    // The block never takes a new transaction while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_image_row) && $stable(m_pair_count))
        else $error("result changed under stall");

    // Pair count never exceeds the matrix size.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pair_count <= 9'd256) else $error("count out of range");

    // A result is never pending just after a transaction is accepted.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");

    // Reflexive and irreflexive together with a present pair imply a non-empty image row.
    a_refl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_reflexive && m_is_irreflexive && m_pair_present
        |-> m_image_row != 16'd0) else $error("flags inconsistent");

endmodule

bind relation_property_checker_unit rpc_checker u_rpc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_pair_present   (m_pair_present),
    .m_image_row      (m_image_row),
    .m_pair_count     (m_pair_count),
    .m_is_reflexive   (m_is_reflexive),
    .m_is_irreflexive (m_is_irreflexive)
);
